// ===== hw/rtl/usb_control_td_chain_builder_unit_assert.svh =====
// ----------------------------------------------------------------------------
// usb_control_td_chain_builder_unit_assert.svh
// Assertion macros shared by the descriptor chain builder RTL.
// ----------------------------------------------------------------------------
`ifndef USB_CONTROL_TD_CHAIN_BUILDER_UNIT_ASSERT_SVH
`define USB_CONTROL_TD_CHAIN_BUILDER_UNIT_ASSERT_SVH

// Same-cycle implication, checked on every clock edge out of reset.
`define TDCB_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on every clock edge out of reset.
`define TDCB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/tdcb_pkg.sv =====
// ----------------------------------------------------------------------------
// tdcb_pkg
// Types, constants and the microcode program of the descriptor chain builder.
// ----------------------------------------------------------------------------
package tdcb_pkg;

    // Longest read accepted, in packets
    localparam int PACKETS_PER_TRANSFER = 32;

    // Descriptor word codes
    localparam logic [7:0]  PID_OUT_CODE    = 8'he1;
    localparam logic [7:0]  PID_IN_CODE     = 8'h69;
    localparam logic [7:0]  PID_SETUP_CODE  = 8'h2d;
    localparam logic [31:0] CTRL_ACTIVE     = 32'h0080_0000;
    localparam logic [31:0] CTRL_SPD        = 32'(1) << 29;
    localparam logic [31:0] CTRL_IOC        = 32'(1) << 24;
    localparam logic [31:0] CTRL_LOW_SPEED  = 32'(1) << 26;
    localparam logic [31:0] CTRL_CERR3      = 32'(3) << 27;
    localparam logic [31:0] LINK_TERMINATE  = 32'h0000_0001;
    localparam logic [31:0] LINK_DEPTH_TD   = 32'h0000_0004;
    localparam logic [10:0] LEN_ZERO_CODE   = 11'h7ff;
    localparam logic [10:0] LEN_SETUP_CODE  = 11'd7;   // 8 bytes, minus one

    // Stream widths
    localparam int IN_TDATA_W  = 96;
    localparam int OUT_TDATA_W = 136;

    typedef logic [2:0] t_upc;

    typedef enum logic [1:0] {PSEL_SETUP, PSEL_IN, PSEL_OUT} t_pid_sel;
    typedef enum logic [1:0] {LSEL_SETUP, LSEL_DATA, LSEL_ZERO} t_len_sel;
    typedef enum logic [1:0] {TSEL_ZERO, TSEL_ONE, TSEL_INDEX} t_tog_sel;
    typedef enum logic [1:0] {BSEL_SETUP, BSEL_DATA, BSEL_NONE} t_buf_sel;
    typedef enum logic [2:0] {
        COND_NEVER, COND_TOO_LONG, COND_NODATA, COND_MORE
    } t_cond;

    // One control word of the sequencer program
    typedef struct packed {
        logic     emit;       // step produces a descriptor
        logic     reject;     // descriptor is the rejection result
        logic     is_last;    // final descriptor of the chain
        logic     spd_more;   // short detect while more data remains
        t_pid_sel pid;
        t_len_sel len;
        t_tog_sel tog;
        t_buf_sel bsel;
        t_cond    jcond;      // jump when this condition holds
        t_upc     jtarget;
        logic     done;       // program ends after this step
    } t_ucode;

    // Datapath status seen by the sequencer
    typedef struct packed {
        logic too_long;
        logic nodata;
        logic more;
        logic out_free;
    } t_dp_flags;

    // Sequencer commands to the datapath
    typedef struct packed {
        logic   load;
        logic   fire;
        t_ucode uc;
    } t_seq_ctl;

    // Program steps
    localparam t_upc UPC_CHECK  = 3'd0;
    localparam t_upc UPC_SETUP  = 3'd1;
    localparam t_upc UPC_DATA   = 3'd2;
    localparam t_upc UPC_OUTST  = 3'd3;
    localparam t_upc UPC_INST   = 3'd4;
    localparam t_upc UPC_REJECT = 3'd5;

    // Microcode ROM
    function automatic t_ucode ucode_word(input t_upc pc);
        t_ucode w;
        w = '{emit: 1'b0, reject: 1'b0, is_last: 1'b0, spd_more: 1'b0,
              pid: PSEL_IN, len: LSEL_ZERO, tog: TSEL_ONE, bsel: BSEL_NONE,
              jcond: COND_NEVER, jtarget: UPC_CHECK, done: 1'b1};
        case (pc)
            UPC_CHECK: begin
                w.jcond   = COND_TOO_LONG;
                w.jtarget = UPC_REJECT;
                w.done    = 1'b0;
            end
            UPC_SETUP: begin
                w.emit    = 1'b1;
                w.pid     = PSEL_SETUP;
                w.len     = LSEL_SETUP;
                w.tog     = TSEL_ZERO;
                w.bsel    = BSEL_SETUP;
                w.jcond   = COND_NODATA;
                w.jtarget = UPC_INST;
                w.done    = 1'b0;
            end
            UPC_DATA: begin
                w.emit     = 1'b1;
                w.spd_more = 1'b1;
                w.pid      = PSEL_IN;
                w.len      = LSEL_DATA;
                w.tog      = TSEL_INDEX;
                w.bsel     = BSEL_DATA;
                w.jcond    = COND_MORE;
                w.jtarget  = UPC_DATA;
                w.done     = 1'b0;
            end
            UPC_OUTST: begin
                w.emit    = 1'b1;
                w.is_last = 1'b1;
                w.pid     = PSEL_OUT;
            end
            UPC_INST: begin
                w.emit    = 1'b1;
                w.is_last = 1'b1;
                w.pid     = PSEL_IN;
            end
            UPC_REJECT: begin
                w.emit    = 1'b1;
                w.reject  = 1'b1;
                w.is_last = 1'b1;
            end
            default: begin
                w.done = 1'b1;
            end
        endcase
        return w;
    endfunction

endpackage

// ===== hw/rtl/tdcb_sequencer.sv =====
// ----------------------------------------------------------------------------
// tdcb_sequencer
// Step counter and jump logic running the microcode program per request.
// ----------------------------------------------------------------------------
module tdcb_sequencer (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_valid,
    output logic                o_s_ready,
    input  tdcb_pkg::t_dp_flags i_flags,
    output tdcb_pkg::t_seq_ctl  o_ctl
);
    import tdcb_pkg::*;

    logic   r_busy, n_busy;
    t_upc   r_pc, n_pc;
    t_ucode uc;
    logic   load, fire, taken;

    // Fetch and condition evaluation
    always_comb begin
        uc = ucode_word(r_pc);
        case (uc.jcond)
            COND_TOO_LONG: taken = i_flags.too_long;
            COND_NODATA:   taken = i_flags.nodata;
            COND_MORE:     taken = i_flags.more;
            default:       taken = 1'b0;
        endcase
    end

    // A step that emits waits for room in the output register
    assign o_s_ready = !r_busy;
    assign load      = i_s_valid && !r_busy;
    assign fire      = r_busy && (!uc.emit || i_flags.out_free);

    // Next step
    always_comb begin
        n_busy = r_busy;
        n_pc   = r_pc;
        if (load) begin
            n_busy = 1'b1;
            n_pc   = UPC_CHECK;
        end else if (fire) begin
            if (taken) begin
                n_pc = uc.jtarget;
            end else if (uc.done) begin
                n_busy = 1'b0;
            end else begin
                n_pc = r_pc + t_upc'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pc   <= UPC_CHECK;
        end else begin
            r_busy <= n_busy;
            r_pc   <= n_pc;
        end
    end

    assign o_ctl = '{load: load, fire: fire, uc: uc};

endmodule

// ===== hw/rtl/tdcb_datapath.sv =====
// ----------------------------------------------------------------------------
// tdcb_datapath
// Request registers, packet walk counters and the descriptor output register.
// ----------------------------------------------------------------------------
module tdcb_datapath (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_valid,
    input  logic [31:0]                          i_cfg_data,
    input  logic [tdcb_pkg::IN_TDATA_W-1:0]      i_tdata,
    input  logic                                 i_tuser,
    input  tdcb_pkg::t_seq_ctl                   i_ctl,
    output tdcb_pkg::t_dp_flags                  o_flags,
    input  logic                                 i_m_ready,
    output logic                                 o_m_valid,
    output logic [tdcb_pkg::OUT_TDATA_W-1:0]     o_m_data,
    output logic                                 o_m_last,
    output logic                                 o_m_user
);
    import tdcb_pkg::*;

    // Configuration and request registers
    logic [26:0] r_base;
    logic        r_op;
    logic [6:0]  r_dev;
    logic [3:0]  r_ep;
    logic        r_low;
    logic [6:0]  r_mps;
    logic [31:0] r_saddr;
    logic [31:0] r_buf;
    logic [11:0] r_bytes_left;
    logic [5:0]  r_idx;
    logic [26:0] r_next_desc;

    // Output register
    logic        r_out_valid;
    logic [5:0]  r_o_idx;
    logic [31:0] r_o_link, r_o_ctrl, r_o_token, r_o_buf;
    logic        r_o_last, r_o_rej;

    logic [5:0]  n_idx;
    logic [31:0] n_link, n_ctrl, n_token, n_buf;
    logic        n_last, n_rej;
    logic [10:0] len_m1;
    logic        tog, spd, more, too_long;
    logic [7:0]  pid;
    logic [12:0] limit;
    logic        emit_fire;

    // Status for the sequencer
    assign limit    = 13'(r_mps) * 13'(PACKETS_PER_TRANSFER);
    assign too_long = r_op && ({1'b0, r_bytes_left} > limit);
    assign more     = r_bytes_left > {5'b0, r_mps};
    assign o_flags  = '{too_long: too_long, nodata: !r_op, more: more,
                        out_free: !r_out_valid || i_m_ready};
    assign emit_fire = i_ctl.fire && i_ctl.uc.emit;

    // Descriptor word assembly
    always_comb begin
        case (i_ctl.uc.len)
            LSEL_SETUP: len_m1 = LEN_SETUP_CODE;
            LSEL_DATA:  len_m1 = more ? ({4'b0, r_mps} - 11'd1)
                                      : (r_bytes_left[10:0] - 11'd1);
            default:    len_m1 = LEN_ZERO_CODE;
        endcase
        case (i_ctl.uc.tog)
            TSEL_ZERO:  tog = 1'b0;
            TSEL_INDEX: tog = r_idx[0];
            default:    tog = 1'b1;
        endcase
        case (i_ctl.uc.pid)
            PSEL_SETUP: pid = PID_SETUP_CODE;
            PSEL_OUT:   pid = PID_OUT_CODE;
            default:    pid = PID_IN_CODE;
        endcase
        case (i_ctl.uc.bsel)
            BSEL_SETUP: n_buf = r_saddr;
            BSEL_DATA:  n_buf = r_buf;
            default:    n_buf = 32'd0;
        endcase
        spd     = i_ctl.uc.spd_more && more;
        n_ctrl  = CTRL_CERR3 | CTRL_ACTIVE
                | (r_low ? CTRL_LOW_SPEED : 32'd0)
                | (spd ? CTRL_SPD : 32'd0)
                | (i_ctl.uc.is_last ? CTRL_IOC : 32'd0);
        n_link  = i_ctl.uc.is_last ? LINK_TERMINATE
                                   : ({r_next_desc, 5'b0} | LINK_DEPTH_TD);
        n_token = {len_m1, 1'b0, tog, r_ep, r_dev, pid};
        n_idx   = r_idx;
        n_last  = i_ctl.uc.is_last;
        n_rej   = 1'b0;
        // Rejection: every field zero but the flags
        if (i_ctl.uc.reject) begin
            n_idx   = 6'd0;
            n_link  = 32'd0;
            n_ctrl  = 32'd0;
            n_token = 32'd0;
            n_buf   = 32'd0;
            n_last  = 1'b1;
            n_rej   = 1'b1;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_base <= i_cfg_data[31:5];
            end
            if (emit_fire) begin
                r_out_valid <= 1'b1;
            end else if (i_m_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Request capture and packet walk
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_op         <= i_tuser;
            r_dev        <= i_tdata[6:0];
            r_ep         <= i_tdata[10:7];
            r_low        <= i_tdata[11];
            r_mps        <= i_tdata[18:12];
            r_bytes_left <= i_tdata[30:19];
            r_saddr      <= i_tdata[62:31];
            r_buf        <= i_tdata[94:63];
            r_idx        <= 6'd0;
            r_next_desc  <= r_base + 27'd1;
        end else if (emit_fire) begin
            r_idx       <= r_idx + 6'd1;
            r_next_desc <= r_next_desc + 27'd1;
            if (i_ctl.uc.len == LSEL_DATA && more) begin
                r_bytes_left <= r_bytes_left - {5'b0, r_mps};
                r_buf        <= r_buf + {25'b0, r_mps};
            end
        end
    end

    // Output payload
    always_ff @(posedge i_clk) begin
        if (emit_fire) begin
            r_o_idx   <= n_idx;
            r_o_link  <= n_link;
            r_o_ctrl  <= n_ctrl;
            r_o_token <= n_token;
            r_o_buf   <= n_buf;
            r_o_last  <= n_last;
            r_o_rej   <= n_rej;
        end
    end

    assign o_m_valid = r_out_valid;
    assign o_m_data  = {2'b0, r_o_buf, r_o_token, r_o_ctrl, r_o_link, r_o_idx};
    assign o_m_last  = r_o_last;
    assign o_m_user  = r_o_rej;

endmodule

// ===== hw/rtl/usb_control_td_chain_builder_unit.sv =====
// ----------------------------------------------------------------------------
// usb_control_td_chain_builder_unit
// Builds the transfer descriptor chain of one USB control request.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one control request per transfer; tuser is the opcode
//   (0 no-data, 1 control read). m_axis returns one descriptor per transfer,
//   tlast on the final descriptor, tuser set on a rejected read (sole result).
//   The cfg channel writes the 32-byte aligned descriptor base address; it
//   is always ready. The user must write it only while no request is in
//   flight; the block itself does not enforce this.
// Timing:
//   A request is taken, the length check runs as its own step, then one
//   descriptor per cycle while the output register has room, for a chain of
//   1..34 descriptors. The microcode step counter issues one step per cycle
//   unless an emitting step waits for the output register. The first
//   descriptor is emitted by the step after the length check.
//   The next request is taken as soon as the last descriptor sits in the
//   output register.
// Reset: synchronous, clears the base address, sequencer and output valid.
// Stall: when m_axis_tready is low and the output register is full, an
//   emitting step holds until the register frees; no descriptor is lost.
`include "usb_control_td_chain_builder_unit_assert.svh"

module usb_control_td_chain_builder_unit (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // Configuration: descriptor_base_address
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [31:0]                          i_cfg_data,
    // Requests
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // device_address[6:0], endpoint_number[10:7], low_speed[11],
    // mps[18:12], data_length[30:19], setup_address[62:31],
    // data_address[94:63], zero[95]
    input  logic [tdcb_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    // opcode[0]
    input  logic                                 s_axis_tuser,
    // Descriptors
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // descriptor_index[5:0], link_word[37:6], control_word[69:38],
    // token_word[101:70], buffer_word[133:102], zero[135:134]
    output logic [tdcb_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    output logic                                 m_axis_tlast,
    // rejected[0]
    output logic                                 m_axis_tuser
);
    import tdcb_pkg::*;

    t_seq_ctl  seq_ctl;
    t_dp_flags dp_flags;

    assign o_cfg_ready = 1'b1;

    // Program sequencer
    tdcb_sequencer u_seq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_axis_tvalid),
        .o_s_ready (s_axis_tready),
        .i_flags   (dp_flags),
        .o_ctl     (seq_ctl)
    );

    // Datapath and output register
    tdcb_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_tdata     (s_axis_tdata),
        .i_tuser     (s_axis_tuser),
        .i_ctl       (seq_ctl),
        .o_flags     (dp_flags),
        .i_m_ready   (m_axis_tready),
        .o_m_valid   (m_axis_tvalid),
        .o_m_data    (m_axis_tdata),
        .o_m_last    (m_axis_tlast),
        .o_m_user    (m_axis_tuser)
    );

    // Checks
    `TDCB_ASSERT_NEXT(a_no_accept_while_busy, s_axis_tvalid && s_axis_tready, !s_axis_tready, "request accepted while a chain is in progress")
    `TDCB_ASSERT_IMPL(a_reject_is_last, m_axis_tvalid && m_axis_tuser, m_axis_tlast, "rejected result without tlast")
    `TDCB_ASSERT_IMPL(a_last_terminates, m_axis_tvalid && m_axis_tlast && !m_axis_tuser, m_axis_tdata[37:6] == LINK_TERMINATE, "final descriptor does not terminate the chain")

endmodule
